/* hdl/gffra_pkg.sv */
// ----------------------------------------------------------------------------
// gffra_pkg
// Shared constants, result codes and the command and status bundles that
// pass between the allocator controller and its datapath.
// ----------------------------------------------------------------------------
package gffra_pkg;

  // Grid geometry and field widths.
  localparam int GRID_SIDE   = 8;
  localparam int COORD_BITS  = 3;
  localparam int CELLS       = GRID_SIDE * GRID_SIDE;
  localparam int CELL_BITS   = 2 * COORD_BITS;
  localparam int HANDLE_BITS = 16;
  localparam int SIZE_BITS   = 4;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_NULL    = 2'd2
  } status_t;

  // Operation codes carried with each input item.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;         // capture the accepted item
    logic    scan_step;    // move to the next anchor position
    logic    place;        // claim the rectangle at the current position
    logic    fill_step;    // write one owner entry of the placed rectangle
    logic    take_anchor;  // latch the looked-up anchor and its handle
    logic    sweep;        // read the next owner entry during removal
    logic    set_res;      // latch the result status
    status_t res_status;
    logic    out_load;     // move the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_remove;
    logic item_null;
    logic bad_size;
    logic idx_busy;
    logic fits;
    logic pos_last;
    logic fill_last;
    logic sweep_last;
    logic out_free;
  } dp_sts_t;

endpackage

/* hdl/gffra_dp.sv */
// ----------------------------------------------------------------------------
// gffra_dp
// Allocator datapath: item registers, occupancy map, owner and handle
// memories, scan and sweep counters, and the result output register.
// ----------------------------------------------------------------------------
module gffra_dp
  import gffra_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_cmd,
  input  logic [HANDLE_BITS-1:0] in_handle,
  input  logic [SIZE_BITS-1:0]   in_width,
  input  logic [SIZE_BITS-1:0]   in_height,
  input  logic [CELL_BITS-1:0]   in_cell,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [COORD_BITS-1:0]  out_row,
  output logic [COORD_BITS-1:0]  out_col,
  output logic [HANDLE_BITS-1:0] out_handle
);

  // Item registers.
  op_t                  op_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [SIZE_BITS-1:0] w_r;
  logic [SIZE_BITS-1:0] h_r;
  logic [CELL_BITS-1:0] idx_r;

  // Working registers.
  logic [CELL_BITS-1:0]   pos;
  logic [COORD_BITS-1:0]  dy;
  logic [COORD_BITS-1:0]  dx;
  logic [CELL_BITS-1:0]   anc_r;
  logic [CELL_BITS-1:0]   swp;
  logic [CELL_BITS-1:0]   swp_d;
  logic                   cmp_vld;
  logic [CELL_BITS-1:0]   anchor_rd;
  logic [HANDLE_BITS-1:0] handle_rd;
  status_t                res_status;
  logic [CELLS-1:0]       occ;

  // Owner anchor per cell and handle per anchor.
  logic [CELL_BITS-1:0]   anchor_mem [CELLS];
  logic [HANDLE_BITS-1:0] handle_mem [CELLS];

  logic [COORD_BITS-1:0] row;
  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS+1:0] row_end;
  logic [COORD_BITS+1:0] col_end;
  logic                  in_bounds;
  logic [GRID_SIDE:0]    pat_wide;
  logic [GRID_SIDE-1:0]  row_bits;
  logic [CELLS-1:0]      mask;
  logic [CELL_BITS-1:0]  fill_addr;
  logic [CELL_BITS-1:0]  rd_addr;

  // Rectangle mask at the current anchor position.
  assign row      = pos[CELL_BITS-1:COORD_BITS];
  assign col      = pos[COORD_BITS-1:0];
  assign row_end  = (COORD_BITS+2)'(row) + (COORD_BITS+2)'(h_r);
  assign col_end  = (COORD_BITS+2)'(col) + (COORD_BITS+2)'(w_r);
  assign in_bounds = (row_end <= (COORD_BITS+2)'(GRID_SIDE)) &&
                     (col_end <= (COORD_BITS+2)'(GRID_SIDE));
  assign pat_wide = ((GRID_SIDE+1)'(1) << w_r) - (GRID_SIDE+1)'(1);
  assign row_bits = pat_wide[GRID_SIDE-1:0] << col;

  always_comb begin
    for (int r = 0; r < GRID_SIDE; r++) begin
      if (((COORD_BITS+2)'(r) >= (COORD_BITS+2)'(row)) &&
          ((COORD_BITS+2)'(r) < row_end)) begin
        mask[r*GRID_SIDE +: GRID_SIDE] = row_bits;
      end else begin
        mask[r*GRID_SIDE +: GRID_SIDE] = '0;
      end
    end
  end

  // Owner entry being written while the placed rectangle is filled.
  assign fill_addr = {anc_r[CELL_BITS-1:COORD_BITS] + dy, anc_r[COORD_BITS-1:0] + dx};
  assign rd_addr   = cmd.sweep ? swp : idx_r;

  // Status toward the controller.
  always_comb begin
    sts.is_remove  = (op_r == OP_REMOVE);
    sts.item_null  = (handle_r == '0);
    sts.bad_size   = (w_r == '0) || (h_r == '0) ||
                     (w_r > SIZE_BITS'(GRID_SIDE)) || (h_r > SIZE_BITS'(GRID_SIDE));
    sts.idx_busy   = occ[idx_r];
    sts.fits       = in_bounds && ((occ & mask) == '0);
    sts.pos_last   = (pos == CELL_BITS'(CELLS - 1));
    sts.fill_last  = ((SIZE_BITS'(dx) + SIZE_BITS'(1)) == w_r) &&
                     ((SIZE_BITS'(dy) + SIZE_BITS'(1)) == h_r);
    sts.sweep_last = (swp == CELL_BITS'(CELLS - 1));
    sts.out_free   = !out_valid || out_ready;
  end

  // Control state: occupancy, compare valid and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cmp_vld <= cmd.sweep;
      if (cmd.place) begin
        occ <= occ | mask;
      end else if (cmp_vld && (anchor_rd == anc_r)) begin
        occ[swp_d] <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item capture, counters and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op_t'(in_cmd);
      handle_r <= in_handle;
      w_r      <= in_width;
      h_r      <= in_height;
      idx_r    <= in_cell;
      pos      <= '0;
    end
    if (cmd.scan_step) begin
      pos <= pos + CELL_BITS'(1);
    end
    if (cmd.place) begin
      anc_r <= pos;
      dy    <= '0;
      dx    <= '0;
    end
    if (cmd.fill_step) begin
      if ((SIZE_BITS'(dx) + SIZE_BITS'(1)) == w_r) begin
        dx <= '0;
        dy <= dy + COORD_BITS'(1);
      end else begin
        dx <= dx + COORD_BITS'(1);
      end
    end
    if (cmd.take_anchor) begin
      anc_r <= anchor_rd;
      swp   <= '0;
    end
    if (cmd.sweep) begin
      swp   <= swp + CELL_BITS'(1);
      swp_d <= swp;
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      if (res_status == ST_DONE) begin
        out_row <= anc_r[CELL_BITS-1:COORD_BITS];
        out_col <= anc_r[COORD_BITS-1:0];
      end else begin
        out_row <= '0;
        out_col <= '0;
      end
      if ((res_status == ST_DONE) && (op_r == OP_REMOVE)) begin
        out_handle <= handle_rd;
      end else begin
        out_handle <= '0;
      end
    end
  end

  // Owner anchor memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.fill_step) begin
      anchor_mem[fill_addr] <= anc_r;
    end
    anchor_rd <= anchor_mem[rd_addr];
  end

  // Handle memory, indexed by anchor cell.
  always_ff @(posedge clk) begin
    if (cmd.place) begin
      handle_mem[pos] <= handle_r;
    end
    if (cmd.take_anchor) begin
      handle_rd <= handle_mem[anchor_rd];
    end
  end

endmodule

/* hdl/gffra_ctrl.sv */
// ----------------------------------------------------------------------------
// gffra_ctrl
// Allocator controller: sequences the anchor scan and fill for inserts and
// the anchor lookup and owner sweep for removals.
// ----------------------------------------------------------------------------
module gffra_ctrl
  import gffra_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FILL,
    S_RM_ANCH,
    S_RM_SWEEP,
    S_RM_TAIL,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.res_status = ST_DONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_remove) begin
          if (sts.idx_busy) begin
            state_next = S_RM_ANCH;
          end else begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_NO_ROOM;
            state_next     = S_FINISH;
          end
        end else if (sts.item_null) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_NULL;
          state_next     = S_FINISH;
        end else if (sts.bad_size) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_NO_ROOM;
          state_next     = S_FINISH;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.fits) begin
          cmd.place  = 1'b1;
          state_next = S_FILL;
        end else if (sts.pos_last) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_NO_ROOM;
          state_next     = S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          cmd.set_res = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_RM_ANCH: begin
        cmd.take_anchor = 1'b1;
        state_next      = S_RM_SWEEP;
      end
      S_RM_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_RM_TAIL;
        end
      end
      S_RM_TAIL: begin
        cmd.set_res = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/grid_first_fit_rect_allocator.sv */
// Insert: accept, decode, scan of up to 64 anchor positions (one per cycle against
// the occupancy flops), fill of width*height owner entries, result. Remove:
// accept, decode, anchor lookup, sweep of all 64 owner entries, result. One item
// is in work at a time; a finished result waits in the output register while the
// next item is accepted. Synchronous reset empties the grid.
// ----------------------------------------------------------------------------
// grid_first_fit_rect_allocator
// First-fit rectangle allocator on an 8x8 occupancy grid with handle lookup
// and whole-rectangle removal.
// ----------------------------------------------------------------------------
module grid_first_fit_rect_allocator
  import gffra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] item_handle, [19:16] item_width, [23:20] item_height,
  // [29:24] cell_index, [31:30] zero
  input  logic [31:0] s_axis_tdata,
  // [0] cmd
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] anchor_row, [5:3] anchor_col, [21:6] removed_handle, [23:22] zero
  output logic [23:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);

  dp_cmd_t                cmd;
  dp_sts_t                sts;
  logic [COORD_BITS-1:0]  out_row;
  logic [COORD_BITS-1:0]  out_col;
  logic [HANDLE_BITS-1:0] out_handle;

  // Sequencer.
  gffra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Grid state and result register.
  gffra_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_cmd     (s_axis_tuser),
    .in_handle  (s_axis_tdata[15:0]),
    .in_width   (s_axis_tdata[19:16]),
    .in_height  (s_axis_tdata[23:20]),
    .in_cell    (s_axis_tdata[29:24]),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (m_axis_tuser),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_handle (out_handle)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata = {2'b00, out_handle, out_col, out_row};

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the first-fit rectangle allocator. A behavioral
// model of the occupancy grid predicts every result at the input transfer.
// A checker compares each output transfer field by field in arrival order.
// Directed cases cover rejects, a full grid and first-fit ordering. Random
// traffic then runs under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gffra_pkg::*;

  // Occupancy kinds tracked by the grid model.
  typedef enum logic [1:0] {
    CELL_FREE   = 2'd0,
    CELL_PART   = 2'd1,
    CELL_ANCHOR = 2'd2
  } cell_kind_t;

  // One result as the block should deliver it.
  typedef struct packed {
    status_t     status;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [15:0] handle;
  } alloc_result_t;

  localparam int MAX_PRINTED = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // Grid model state.
  cell_kind_t  grid_kind [CELLS];
  logic [5:0]  grid_owner [CELLS];
  logic [15:0] owner_handle [CELLS];

  alloc_result_t expected_results [$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  grid_first_fit_rect_allocator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk = ~clk;

  // Apply one item to the grid model and return the result it must produce.
  function automatic alloc_result_t predict_alloc(op_t op, logic [15:0] hnd, logic [3:0] w,
                                                  logic [3:0] h, logic [5:0] idx);
    alloc_result_t res;
    bit found;
    bit clear;
    int wi, hi, r, c, y, x, a;
    res = '{status: ST_NO_ROOM, row: 3'd0, col: 3'd0, handle: 16'd0};
    wi = w;
    hi = h;
    if (op == OP_INSERT) begin
      if (hnd == '0) begin
        res.status = ST_NULL;
      end else if (wi != 0 && hi != 0 && wi <= GRID_SIDE && hi <= GRID_SIDE) begin
        found = 1'b0;
        for (r = 0; r + hi <= GRID_SIDE && !found; r++) begin
          for (c = 0; c + wi <= GRID_SIDE && !found; c++) begin
            clear = 1'b1;
            for (y = 0; y < hi; y++)
              for (x = 0; x < wi; x++)
                if (grid_kind[(r + y) * GRID_SIDE + c + x] != CELL_FREE) clear = 1'b0;
            if (clear) begin
              // First empty anchor in row-major order claims the rectangle.
              found = 1'b1;
              a = r * GRID_SIDE + c;
              for (y = 0; y < hi; y++) begin
                for (x = 0; x < wi; x++) begin
                  grid_kind[(r + y) * GRID_SIDE + c + x] = CELL_PART;
                  grid_owner[(r + y) * GRID_SIDE + c + x] = 6'(a);
                end
              end
              grid_kind[a] = CELL_ANCHOR;
              owner_handle[a] = hnd;
              res.status = ST_DONE;
              res.row = 3'(r);
              res.col = 3'(c);
            end
          end
        end
      end
    end else if (grid_kind[idx] != CELL_FREE) begin
      // Free every cell owned by the same anchor and return its handle.
      a = grid_owner[idx];
      res.status = ST_DONE;
      res.row = 3'(a / GRID_SIDE);
      res.col = 3'(a % GRID_SIDE);
      res.handle = owner_handle[a];
      for (c = 0; c < CELLS; c++) begin
        if (grid_kind[c] != CELL_FREE && grid_owner[c] == 6'(a)) begin
          grid_kind[c] = CELL_FREE;
          grid_owner[c] = '0;
        end
      end
      owner_handle[a] = '0;
    end
    return res;
  endfunction

  // Print one line per mismatch, up to a limit, and count all of them.
  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("ERROR at %0t ns: %s, expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // Offer one item from a falling edge and record its prediction on transfer.
  task automatic send_item(op_t op, logic [15:0] hnd, logic [3:0] w, logic [3:0] h,
                           logic [5:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, idx, h, w, hnd};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    expected_results.push_back(predict_alloc(op, hnd, w, h, idx));
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted result has arrived.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
  endtask

  // Null handles, zero and oversized rectangles, removal of empty cells.
  task automatic test_reject_cases();
    send_item(OP_INSERT, 16'h0000, 4'd1, 4'd1, 6'd0);
    send_item(OP_INSERT, 16'h0000, 4'd15, 4'd15, 6'd63);
    send_item(OP_INSERT, 16'h0001, 4'd0, 4'd1, 6'd0);
    send_item(OP_INSERT, 16'h0001, 4'd1, 4'd0, 6'd0);
    send_item(OP_INSERT, 16'hFFFF, 4'd9, 4'd8, 6'd0);
    send_item(OP_INSERT, 16'hFFFF, 4'd8, 4'd15, 6'd0);
    send_item(OP_REMOVE, 16'hFFFF, 4'd1, 4'd1, 6'd0);
    send_item(OP_REMOVE, 16'h0000, 4'd0, 4'd0, 6'd63);
  endtask

  // A whole-grid rectangle, a refused insert, two removals by its last cell.
  task automatic test_whole_grid();
    send_item(OP_INSERT, 16'hFFFF, 4'd8, 4'd8, 6'd0);
    send_item(OP_INSERT, 16'h0002, 4'd1, 4'd1, 6'd0);
    send_item(OP_REMOVE, 16'h0000, 4'd0, 4'd0, 6'd63);
    send_item(OP_REMOVE, 16'h0000, 4'd0, 4'd0, 6'd63);
  endtask

  // Row-major first fit, a tall rectangle with no room, reuse of freed space,
  // and removal through cells that are not the anchor.
  task automatic test_first_fit_order();
    send_item(OP_INSERT, 16'h0001, 4'd3, 4'd2, 6'd0);
    send_item(OP_INSERT, 16'h8000, 4'd8, 4'd1, 6'd0);
    send_item(OP_INSERT, 16'h1234, 4'd5, 4'd2, 6'd0);
    send_item(OP_INSERT, 16'hABCD, 4'd1, 4'd8, 6'd0);
    send_item(OP_INSERT, 16'h00FF, 4'd1, 4'd1, 6'd63);
    send_item(OP_REMOVE, 16'hDEAD, 4'd15, 4'd15, 6'd9);
    send_item(OP_INSERT, 16'h5A5A, 4'd2, 4'd2, 6'd0);
    send_item(OP_REMOVE, 16'h0000, 4'd0, 4'd0, 6'd23);
    send_item(OP_REMOVE, 16'h0000, 4'd0, 4'd0, 6'd12);
    send_item(OP_REMOVE, 16'h0000, 4'd0, 4'd0, 6'd24);
    send_item(OP_REMOVE, 16'h0000, 4'd0, 4'd0, 6'd0);
    send_item(OP_INSERT, 16'h7777, 4'd1, 4'd8, 6'd0);
    send_item(OP_REMOVE, 16'h0000, 4'd0, 4'd0, 6'd56);
  endtask

  // Mostly well-formed inserts and removals of placed rectangles, with some
  // null handles, bad sizes and removals of arbitrary cells mixed in.
  task automatic test_random_traffic(int count);
    int pick;
    int busy_cells [$];
    logic [3:0] w, h;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if ($urandom_range(4) == 0) begin
        w = 4'($urandom_range(1, GRID_SIDE));
        h = 4'($urandom_range(1, GRID_SIDE));
      end else begin
        w = 4'($urandom_range(1, 3));
        h = 4'($urandom_range(1, 3));
      end
      if (pick < 55) begin
        send_item(OP_INSERT, 16'($urandom_range(1, 65535)), w, h, 6'($urandom));
      end else if (pick < 85) begin
        busy_cells.delete();
        for (int c = 0; c < CELLS; c++)
          if (grid_kind[c] != CELL_FREE) busy_cells.push_back(c);
        if (busy_cells.size() != 0)
          send_item(OP_REMOVE, 16'($urandom), 4'($urandom), 4'($urandom),
                    6'(busy_cells[$urandom_range(busy_cells.size() - 1)]));
        else
          send_item(OP_REMOVE, 16'($urandom), 4'($urandom), 4'($urandom), 6'($urandom));
      end else if (pick < 90) begin
        send_item(OP_INSERT, 16'h0000, 4'($urandom), 4'($urandom), 6'($urandom));
      end else if (pick < 95) begin
        if ($urandom_range(1) == 0) begin
          w = ($urandom_range(2) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
        end else begin
          h = ($urandom_range(2) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
        end
        send_item(OP_INSERT, 16'($urandom_range(1, 65535)), w, h, 6'($urandom));
      end else begin
        send_item(OP_REMOVE, 16'($urandom), 4'($urandom), 4'($urandom), 6'($urandom));
      end
    end
  endtask

  // Receiver: stall the result channel at the current rate.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected", '0,
                        {6'd0, m_axis_tuser, m_axis_tdata});
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", want.status, m_axis_tuser);
        if (m_axis_tdata[2:0] !== want.row)
          report_mismatch("anchor_row", want.row, m_axis_tdata[2:0]);
        if (m_axis_tdata[5:3] !== want.col)
          report_mismatch("anchor_col", want.col, m_axis_tdata[5:3]);
        if (m_axis_tdata[21:6] !== want.handle)
          report_mismatch("removed_handle", want.handle, m_axis_tdata[21:6]);
        if (m_axis_tdata[23:22] !== 2'b00)
          report_mismatch("tdata padding", '0, m_axis_tdata[23:22]);
      end
    end
  end

  // Main sequence: reset, directed cases, then random traffic in phases.
  initial begin
    for (int c = 0; c < CELLS; c++) begin
      grid_kind[c] = CELL_FREE;
      grid_owner[c] = '0;
      owner_handle[c] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reject_cases();
    test_whole_grid();
    test_first_fit_order();
    wait_results_drained();

    // No idling on either side.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(215);
    wait_results_drained();

    // Sender mostly idle.
    send_idle_pct = 68;
    recv_stall_pct = 0;
    test_random_traffic(210);
    wait_results_drained();

    // Receiver mostly stalling.
    send_idle_pct = 0;
    recv_stall_pct = 68;
    test_random_traffic(210);
    wait_results_drained();

    // Light idling on both sides.
    send_idle_pct = 13;
    recv_stall_pct = 13;
    test_random_traffic(215);
    wait_results_drained();

    // Let any stray result show up before the verdict.
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("grid_first_fit_rect_allocator verification clean");
    end else begin
      $display("grid_first_fit_rect_allocator verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("grid_first_fit_rect_allocator verification failed");
    $finish;
  end

endmodule

/* filelist.f */
hdl/gffra_pkg.sv
hdl/gffra_dp.sv
hdl/gffra_ctrl.sv
hdl/grid_first_fit_rect_allocator.sv
verif/tb.sv
